[rtl/tfm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants for the topic filter match table.
// ----------------------------------------------------------------------------
package tfm_pkg;

  // Table geometry
  localparam int SLOTS      = 8;
  localparam int FILTER_LEN = 64;
  localparam int ADDR_W     = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
  localparam int CUR_W      = $clog2(FILTER_LEN + 1);
  localparam int MASK_W     = 8;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 3;
  localparam int POS_W  = 7;

  // Special filter characters
  localparam logic [7:0] SEP_CHAR  = 8'h2F;
  localparam logic [7:0] PLUS_CHAR = 8'h2B;
  localparam logic [7:0] HASH_CHAR = 8'h23;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NAME   = 2'd3;

  // Configuration register indexes
  localparam logic REG_DEFAULT_PRESENT = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [7:0]        data_byte;
    logic              last_byte;
  } cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] match_mask;
    logic              any_match;
    logic              use_default;
  } res_t;

  // Control from the sequencer to one slot
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_byte;
    logic              commit;
    logic              remove;
    logic [CUR_W-1:0]  len;
    logic              rd_en;
    logic              step;
    logic              restart;
    logic [7:0]        name_byte;
  } tfm_slot_ctl_t;

endpackage
`default_nettype wire

[rtl/tfm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tfm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/tfm_slot.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tfm_slot
// One filter slot: its byte bank, length, valid bit and match progress.
// ----------------------------------------------------------------------------
module tfm_slot
  import tfm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tfm_slot_ctl_t ctl,
  output logic               hit
);

  logic [CUR_W-1:0] length;
  logic             valid;
  logic [CUR_W-1:0] cursor;
  logic             alive;
  logic             plus_m;
  logic             hash_m;

  logic [CUR_W-1:0] cursor_next;
  logic             alive_next;
  logic             plus_next;
  logic             hash_next;
  logic [7:0]       fbyte;
  logic [7:0]       nbyte;

  // Filter byte bank, read at the cursor
  tfm_ram #(
    .DEPTH (FILTER_LEN),
    .WIDTH (8)
  ) u_bank (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.wr_addr),
    .wdata (ctl.wr_byte),
    .re    (ctl.rd_en),
    .raddr (cursor[ADDR_W-1:0]),
    .rdata (fbyte)
  );

  assign nbyte = ctl.name_byte;

  // Advance match progress by one name byte
  always_comb begin
    cursor_next = cursor;
    alive_next  = alive;
    plus_next   = plus_m;
    hash_next   = hash_m;
    if (alive && !hash_m && !(plus_m && nbyte != SEP_CHAR)) begin
      plus_next = 1'b0;
      if (cursor >= length) begin
        alive_next = 1'b0;
      end else if (nbyte == SEP_CHAR && fbyte != SEP_CHAR) begin
        alive_next = 1'b0;
      end else if (fbyte == PLUS_CHAR) begin
        plus_next   = 1'b1;
        cursor_next = cursor + CUR_W'(1);
      end else if (fbyte == HASH_CHAR) begin
        hash_next   = 1'b1;
        cursor_next = cursor + CUR_W'(1);
      end else if (fbyte != nbyte) begin
        alive_next = 1'b0;
      end else begin
        cursor_next = cursor + CUR_W'(1);
      end
    end
  end

  // Slot matches when the whole filter was consumed
  assign hit = valid && alive_next && (cursor_next == length);

  // Table entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      valid  <= 1'b0;
    end else if (ctl.commit) begin
      length <= ctl.len;
      valid  <= 1'b1;
    end else if (ctl.remove) begin
      valid  <= 1'b0;
    end
  end

  // Match progress; restart after the last name byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      alive  <= 1'b1;
      plus_m <= 1'b0;
      hash_m <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.restart) begin
        cursor <= '0;
        alive  <= 1'b1;
        plus_m <= 1'b0;
        hash_m <= 1'b0;
      end else begin
        cursor <= cursor_next;
        alive  <= alive_next;
        plus_m <= plus_next;
        hash_m <= hash_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/topic_filter_match_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// topic_filter_match_table
// Topic filter table with per-slot byte banks, streaming name matcher.
// ----------------------------------------------------------------------------
// Filter write, commit and remove transactions act at their accepting edge.
// For a topic name byte, the accepting edge reads every slot's bank at that
// slot's cursor, and the execute state then compares the bytes and updates
// the cursors, which address the reads for the following name byte. The
// result of the last name byte goes to an output register; the block keeps
// taking table transactions while it waits there, and holds a further last
// name byte until the register is free. The filter banks come out of reset
// without a clearing pass: a filter byte must be written before its slot is
// committed with a length covering it.
module topic_filter_match_table
  import tfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Item channel
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_t        cmd,
  // Result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_t             res,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int EXT_W = (SLOTS > MASK_W) ? SLOTS : MASK_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t            state;
  logic              default_present;
  logic [7:0]        name_byte;
  logic              name_last;
  logic              accept;
  logic              exec_done;
  logic              step;
  logic              pos_ok;
  logic [CUR_W-1:0]  len_sat;
  logic [SLOTS-1:0]  hits;
  logic [EXT_W-1:0]  hits_ext;
  tfm_slot_ctl_t     ctl [SLOTS];

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_present <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEFAULT_PRESENT) begin
      default_present <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DEFAULT_PRESENT) begin
      prdata[0] = default_present;
    end
  end

  // Handshake and sequencing
  assign cmd_stall = (state == ST_EXEC);
  assign accept    = cmd_valid && !cmd_stall;
  assign exec_done = !(name_last && res_valid && res_stall);
  assign step      = (state == ST_EXEC) && exec_done;

  // Clamp length and check write position
  always_comb begin
    pos_ok  = (int'(cmd.position) < FILTER_LEN);
    len_sat = (int'(cmd.position) > FILTER_LEN) ? CUR_W'(FILTER_LEN) : CUR_W'(cmd.position);
  end

  // Fan control out to the slots
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      ctl[s].wr_en     = accept && cmd.command == CMD_WRITE && int'(cmd.slot) == s && pos_ok;
      ctl[s].wr_addr   = ADDR_W'(cmd.position);
      ctl[s].wr_byte   = cmd.data_byte;
      ctl[s].commit    = accept && cmd.command == CMD_COMMIT && int'(cmd.slot) == s;
      ctl[s].remove    = accept && cmd.command == CMD_REMOVE && int'(cmd.slot) == s;
      ctl[s].len       = len_sat;
      ctl[s].rd_en     = accept && cmd.command == CMD_NAME;
      ctl[s].step      = step;
      ctl[s].restart   = name_last;
      ctl[s].name_byte = name_byte;
    end
  end

  // Slot engines
  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    tfm_slot u_slot (
      .clk (clk),
      .rst (rst),
      .ctl (ctl[g]),
      .hit (hits[g])
    );
  end

  assign hits_ext = EXT_W'(hits);

  // Latch the name byte and step through the compare cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && cmd.command == CMD_NAME) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_NAME) begin
      name_byte <= cmd.data_byte;
      name_last <= cmd.last_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && name_last) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && name_last) begin
      res.match_mask  <= hits_ext[MASK_W-1:0];
      res.any_match   <= |hits;
      res.use_default <= ~(|hits) & default_present;
    end
  end

endmodule
`default_nettype wire
